// ===== design/awelp_pkg.sv =====
// Shared types and constants for the wheel encoder line parser.
// No dependencies; imported by awelp_field and ascii_wheel_encoder_line_parser.
`timescale 1ns / 1ps
`default_nettype none

package awelp_pkg;

	// ASCII codes
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_V     = 8'h56;

	// frame lengths
	localparam int LEN_VEL = 14;
	localparam int LEN_POS = 24;

	// field windows [lo, hi)
	localparam int F0_LO     = 3;
	localparam int F0_HI_VEL = 7;
	localparam int F1_LO_VEL = 8;
	localparam int F1_HI_VEL = 12;
	localparam int F0_HI_POS = 12;
	localparam int F1_LO_POS = 13;
	localparam int F1_HI_POS = 22;

	// positions inside the line flags
	localparam int FLG_HASH = 0;
	localparam int FLG_CR   = 1;
	localparam int FLG_V    = 2;
	localparam int FLG_P    = 3;

	localparam logic MODE_VEL = 1'b0;
	localparam logic MODE_POS = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_HASH   = 3'd1,
		ST_NO_CR     = 3'd2,
		ST_BAD_LEN   = 3'd3,
		ST_BAD_HDR   = 3'd4,
		ST_NO_DIGITS = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		PH_BLANK  = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_STOP   = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic        neg;
		logic        ok;
		logic [31:0] value;
	} field_t;

endpackage

`default_nettype wire

// ===== design/awelp_field.sv =====
// Decimal field scanner: blanks, optional sign, digits up to the first non-digit.
// Depends on awelp_pkg (field_t, phase_t, ASCII constants).
`timescale 1ns / 1ps
`default_nettype none

module awelp_field import awelp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,     // a byte is consumed this cycle
	input  wire logic       hit,      // byte lies inside this field's window
	input  wire logic       clear,    // line ends with this byte
	input  wire logic [7:0] rx_byte,
	output field_t          nxt       // state after this byte
);

	field_t      cur_q;
	logic        is_digit;
	logic        is_blank;
	logic [31:0] acc;

	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_blank = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
	// value * 10 + digit, wrapping
	assign acc = {cur_q.value[28:0], 3'b000} + {cur_q.value[30:0], 1'b0}
		+ {28'd0, rx_byte[3:0]};

	always_comb begin
		nxt = cur_q;
		if (hit) begin
			unique case (cur_q.phase)
				PH_BLANK: begin
					if (is_blank) begin
						nxt.phase = PH_BLANK;
					end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
						nxt.neg   = (rx_byte == CH_MINUS);
						nxt.phase = PH_SIGN;
					end else if (is_digit) begin
						nxt.value = acc;
						nxt.ok    = 1'b1;
						nxt.phase = PH_DIGITS;
					end else begin
						nxt.phase = PH_STOP;
					end
				end
				PH_SIGN, PH_DIGITS: begin
					if (is_digit) begin
						nxt.value = acc;
						nxt.ok    = 1'b1;
						nxt.phase = PH_DIGITS;
					end else begin
						nxt.phase = PH_STOP;
					end
				end
				default: begin
					nxt.phase = PH_STOP;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (step) begin
			if (clear) begin
				cur_q <= '0;
			end else begin
				cur_q <= nxt;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/ascii_wheel_encoder_line_parser.sv =====
// Top level of the wheel encoder line parser: byte framing, line checks, odometry.
// Depends on awelp_pkg and awelp_field.
//
//  channel  dir  width  contents
//  s_*      in   8      tdata[7:0] rx_byte
//  m_*      out  136    tdata[2:0] status, [34:3] odo_left, [66:35] odo_right,
//                       [98:67] velocity_left, [130:99] velocity_right, rest zero
//  cfg_*    in   1      cfg_data = log_mode (0 velocity, 1 position)
//
// One byte per cycle, sustained while no finished line is held up by back-pressure.
// Byte to result path: input register, line-end capture register, result register.
// A non-final byte never produces a result; the final byte of a line produces one.
// Back-pressure on m_* stalls the line-end stage and the byte stage only when a
// finished line needs to move forward. arst_n clears all line and odometry state
// and sets log_mode to 1.
`timescale 1ns / 1ps
`default_nettype none

module ascii_wheel_encoder_line_parser import awelp_pkg::*; #(
	parameter int MAX_LINE = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [135:0]      m_tdata,   // [2:0] status, [34:3] odo_left,
	                                     // [66:35] odo_right, [98:67] velocity_left,
	                                     // [130:99] velocity_right
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_data   // log_mode
);

	localparam int IDX_W = $clog2(MAX_LINE + 1);

	logic             mode_q;

	// byte stage
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [IDX_W-1:0] idx_q;
	logic [3:0]       flags_q;
	logic [3:0]       flags_nxt;
	logic [IDX_W-1:0] len;
	logic             line_end;
	logic             hit0;
	logic             hit1;
	logic [IDX_W-1:0] f0_hi;
	logic [IDX_W-1:0] f1_lo;
	logic [IDX_W-1:0] f1_hi;
	field_t           fld_nxt [2];

	// line-end stage
	logic             valid_s2;
	logic [3:0]       flags_s2;
	logic             len14_s2;
	logic             len24_s2;
	field_t           fld_s2 [2];

	// odometry state and result register
	logic [31:0]      run_q  [2];
	logic [31:0]      vel_q  [2];
	logic [31:0]      prev_q [2];
	logic             out_valid_q;
	status_t          status_q;
	logic [31:0]      out_pos_q [2];
	logic [31:0]      out_vel_q [2];

	status_t          status;
	logic [31:0]      sval     [2];
	logic [31:0]      run_sum  [2];
	logic [31:0]      vel_diff [2];
	logic [31:0]      new_run  [2];
	logic [31:0]      new_vel  [2];
	logic [31:0]      new_prev [2];

	logic             out_free;
	logic             s2_adv;
	logic             s1_adv;

	// flow control
	assign out_free  = !out_valid_q || m_tready;
	assign s2_adv    = valid_s2 && out_free;
	assign s1_adv    = valid_s1 && (!line_end || !valid_s2 || s2_adv);
	assign s_tready  = !valid_s1 || s1_adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_POS;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// windows follow the mode at each byte's arrival
	assign f0_hi = (mode_q == MODE_POS) ? IDX_W'(F0_HI_POS) : IDX_W'(F0_HI_VEL);
	assign f1_lo = (mode_q == MODE_POS) ? IDX_W'(F1_LO_POS) : IDX_W'(F1_LO_VEL);
	assign f1_hi = (mode_q == MODE_POS) ? IDX_W'(F1_HI_POS) : IDX_W'(F1_HI_VEL);
	assign hit0  = (idx_q >= IDX_W'(F0_LO)) && (idx_q < f0_hi);
	assign hit1  = (idx_q >= f1_lo) && (idx_q < f1_hi);

	assign len      = idx_q + IDX_W'(1);
	assign line_end = (byte_s1 == CH_LF) || (len == IDX_W'(MAX_LINE));

	always_comb begin
		flags_nxt = flags_q;
		if (idx_q == '0 && byte_s1 == CH_HASH) begin
			flags_nxt[FLG_HASH] = 1'b1;
		end
		if (byte_s1 == CH_CR) begin
			flags_nxt[FLG_CR] = 1'b1;
		end
		if (idx_q == IDX_W'(1) && byte_s1 == CH_V) begin
			flags_nxt[FLG_V] = 1'b1;
		end
		if (idx_q == IDX_W'(1) && byte_s1 == CH_P) begin
			flags_nxt[FLG_P] = 1'b1;
		end
	end

	awelp_field u_field_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (s1_adv),
		.hit     (hit0),
		.clear   (line_end),
		.rx_byte (byte_s1),
		.nxt     (fld_nxt[0])
	);

	awelp_field u_field_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (s1_adv),
		.hit     (hit1),
		.clear   (line_end),
		.rx_byte (byte_s1),
		.nxt     (fld_nxt[1])
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			flags_q <= '0;
		end else if (s1_adv) begin
			if (line_end) begin
				idx_q   <= '0;
				flags_q <= '0;
			end else begin
				idx_q   <= len;
				flags_q <= flags_nxt;
			end
		end
	end

	// line-end capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv && line_end) begin
			valid_s2 <= 1'b1;
		end else if (s2_adv) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && line_end) begin
			flags_s2  <= flags_nxt;
			len14_s2  <= (len == IDX_W'(LEN_VEL));
			len24_s2  <= (len == IDX_W'(LEN_POS));
			fld_s2[0] <= fld_nxt[0];
			fld_s2[1] <= fld_nxt[1];
		end
	end

	// checks in priority order; the user must keep mode stable while a line is in flight (the block does not enforce it)
	always_comb begin
		if (!flags_s2[FLG_HASH]) begin
			status = ST_NO_HASH;
		end else if (!flags_s2[FLG_CR]) begin
			status = ST_NO_CR;
		end else if (!((mode_q == MODE_POS) ? len24_s2 : len14_s2)) begin
			status = ST_BAD_LEN;
		end else if (!((mode_q == MODE_POS) ? flags_s2[FLG_P] : flags_s2[FLG_V])) begin
			status = ST_BAD_HDR;
		end else if (!(fld_s2[0].ok && fld_s2[1].ok)) begin
			status = ST_NO_DIGITS;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			sval[k]     = fld_s2[k].neg ? (32'd0 - fld_s2[k].value) : fld_s2[k].value;
			// sign folded into one add/sub each
			run_sum[k]  = fld_s2[k].neg ? (run_q[k] - fld_s2[k].value)
			                            : (run_q[k] + fld_s2[k].value);
			vel_diff[k] = fld_s2[k].neg ? (32'd0 - fld_s2[k].value - prev_q[k])
			                            : (fld_s2[k].value - prev_q[k]);
			if (mode_q == MODE_POS) begin
				new_run[k]  = sval[k];
				new_vel[k]  = vel_diff[k];
				new_prev[k] = sval[k];
			end else begin
				new_run[k]  = run_sum[k];
				new_vel[k]  = sval[k];
				new_prev[k] = prev_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 2; k++) begin
				run_q[k]  <= '0;
				vel_q[k]  <= '0;
				prev_q[k] <= '0;
			end
		end else if (s2_adv && status == ST_OK) begin
			for (int k = 0; k < 2; k++) begin
				run_q[k]  <= new_run[k];
				vel_q[k]  <= new_vel[k];
				prev_q[k] <= new_prev[k];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s2_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			status_q <= status;
			for (int k = 0; k < 2; k++) begin
				out_pos_q[k] <= (status == ST_OK) ? new_run[k] : run_q[k];
				out_vel_q[k] <= (status == ST_OK) ? new_vel[k] : vel_q[k];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_vel_q[1], out_vel_q[0], out_pos_q[1], out_pos_q[0],
		status_q};

endmodule

`default_nettype wire
